// ===== rtl/sle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg - shared definitions for the sequential list engine
// Request codes, status codes, reduction group size and the control word
// broadcast to every list cell.
// ----------------------------------------------------------------------------
package sle_pkg;

    // request codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BADPOS   = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_EMPTY    = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

    // cells per first-level reduction group
    localparam int GROUP_SIZE = 16;
    localparam int GROUP_OFF_W = $clog2(GROUP_SIZE);

    typedef struct packed {
        logic       ins;
        logic       del;
        logic [7:0] pos;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sequential_list_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine - ordered list of signed words in a chain of cells
// Insert, delete, read, find and clear on a list of up to CAPACITY entries.
//
//   channel  | ports                                   | dir | handshake
//   request  | s_op, s_position, s_item_value          | in  | s_valid/s_ready
//   result   | m_status, m_read_value, m_found_index,  | out | m_valid/m_ready
//            | m_list_length                           |     |
//
// Each request passes through an execute state, in which the cells shift and
// the group reduction registers capture, and a final state for the reduction
// across groups. A new beat is taken in the final state of the last one, while
// the result register is free. Reset clears the length only; entries need no
// clearing. A stalled result holds the final stage, and so the request port.
// ----------------------------------------------------------------------------
module sequential_list_engine import sle_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [7:0]  s_position,
    input  wire logic [31:0] s_item_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_read_value,
    output logic [7:0]       m_found_index,
    output logic [8:0]       m_list_length
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int NGROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int NCELLS  = NGROUPS * GROUP_SIZE;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RED  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [2:0]            req_op_reg;
    logic [7:0]            req_pos_reg;
    logic [DATA_WIDTH-1:0] req_key_reg;
    logic [2:0]            exec_status_reg, exec_status_next;

    logic                  m_valid_reg, m_valid_next;
    logic [2:0]            m_status_reg, m_status_next;
    logic [31:0]           m_read_value_reg, m_read_value_next;
    logic [7:0]            m_found_index_reg, m_found_index_next;
    logic [8:0]            m_list_length_reg, m_list_length_next;

    logic        accept;
    logic        out_free;
    logic        load_out;
    logic        ins_ok;
    logic        del_ok;
    cell_ctrl_t  ctrl;
    logic [63:0] key_ext;

    logic [DATA_WIDTH-1:0]  cell_word [NCELLS];
    logic [NCELLS-1:0]      cell_sel;
    logic [NCELLS-1:0]      cell_match;
    logic [NGROUPS-1:0]     grp_sel_any;
    logic [DATA_WIDTH-1:0]  grp_sel_word [NGROUPS];
    logic [NGROUPS-1:0]     grp_match_any;
    logic [GROUP_OFF_W-1:0] grp_match_off [NGROUPS];

    logic [DATA_WIDTH-1:0] fin_word;
    logic [63:0]           fin_word_ext;
    logic                  fin_match;
    int                    fin_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_RED) && out_free);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == ST_RED) && out_free;
    assign key_ext  = {32'b0, s_item_value};

    // decision on the request, made against the length before the update
    always_comb begin
        ins_ok           = 1'b0;
        del_ok           = 1'b0;
        count_next       = count_reg;
        exec_status_next = STAT_OK;
        case (req_op_reg)
            OP_INSERT: begin
                if (int'(req_pos_reg) > int'(count_reg)) begin
                    exec_status_next = STAT_BADPOS;
                end else if (count_reg == CNT_W'(CAPACITY)) begin
                    exec_status_next = STAT_FULL;
                end else begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (count_reg == '0) begin
                    exec_status_next = STAT_EMPTY;
                end else if (int'(req_pos_reg) >= int'(count_reg)) begin
                    exec_status_next = STAT_BADPOS;
                end else begin
                    del_ok     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (int'(req_pos_reg) >= int'(count_reg)) begin
                    exec_status_next = STAT_BADPOS;
                end
            end
            OP_FIND: begin
                exec_status_next = STAT_NOTFOUND;
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                exec_status_next = STAT_BADPOS;
            end
        endcase
    end

    assign ctrl.ins = (state_reg == ST_EXEC) && ins_ok;
    assign ctrl.del = (state_reg == ST_EXEC) && del_ok;
    assign ctrl.pos = req_pos_reg;

    // cell chain, padded to whole groups
    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        if (i < CAPACITY) begin : g_live
            logic [DATA_WIDTH-1:0] left_word;
            logic [DATA_WIDTH-1:0] right_word;
            if (i == 0) begin : g_first
                assign left_word = '0;
            end else begin : g_mid
                assign left_word = cell_word[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign right_word = '0;
            end else begin : g_inner
                assign right_word = cell_word[i+1];
            end
            sle_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (i),
                .CNT_W      (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .key        (req_key_reg),
                .left_data  (left_word),
                .right_data (right_word),
                .count      (count_reg),
                .data       (cell_word[i]),
                .hit_pos    (cell_sel[i]),
                .hit_key    (cell_match[i])
            );
        end else begin : g_pad
            assign cell_word[i]  = '0;
            assign cell_sel[i]   = 1'b0;
            assign cell_match[i] = 1'b0;
        end
    end

    for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
        logic [DATA_WIDTH-1:0] words [GROUP_SIZE];
        for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_w
            assign words[k] = cell_word[g*GROUP_SIZE + k];
        end
        sle_group #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_group (
            .aclk      (aclk),
            .capture   (state_reg == ST_EXEC),
            .sel       (cell_sel[g*GROUP_SIZE +: GROUP_SIZE]),
            .match     (cell_match[g*GROUP_SIZE +: GROUP_SIZE]),
            .word      (words),
            .sel_any   (grp_sel_any[g]),
            .sel_word  (grp_sel_word[g]),
            .match_any (grp_match_any[g]),
            .match_off (grp_match_off[g])
        );
    end

    // second-level reduction across groups
    always_comb begin
        fin_word  = '0;
        fin_match = |grp_match_any;
        fin_idx   = 0;
        for (int g = 0; g < NGROUPS; g++) begin
            fin_word = fin_word | (grp_sel_word[g] & {DATA_WIDTH{grp_sel_any[g]}});
        end
        for (int g = NGROUPS - 1; g >= 0; g--) begin
            if (grp_match_any[g]) begin
                fin_idx = g * GROUP_SIZE + int'(grp_match_off[g]);
            end
        end
    end

    assign fin_word_ext = 64'(fin_word);

    always_comb begin
        m_status_next      = exec_status_reg;
        m_read_value_next  = '0;
        m_found_index_next = '0;
        m_list_length_next = 9'(count_reg);
        if (req_op_reg == OP_READ && exec_status_reg == STAT_OK) begin
            m_read_value_next = fin_word_ext[31:0];
        end
        if (req_op_reg == OP_FIND && fin_match) begin
            m_status_next      = STAT_OK;
            m_found_index_next = 8'(fin_idx);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RED;
            end
            ST_RED: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end else if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_EXEC) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_op_reg  <= s_op;
            req_pos_reg <= s_position;
            req_key_reg <= key_ext[DATA_WIDTH-1:0];
        end
        if (state_reg == ST_EXEC) begin
            exec_status_reg <= exec_status_next;
        end
        if (load_out) begin
            m_status_reg      <= m_status_next;
            m_read_value_reg  <= m_read_value_next;
            m_found_index_reg <= m_found_index_next;
            m_list_length_reg <= m_list_length_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_found_index = m_found_index_reg;
    assign m_list_length = m_list_length_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= CAPACITY)
        else $error("list length beyond capacity");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted beat did not enter execute");

    a_result_from_red: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RED))
        else $error("result raised outside the final stage");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list by one");

    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.del |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink the list by one");

endmodule
`default_nettype wire

// ===== rtl/sle_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_cell - one list entry
// Holds one word, takes its left neighbor (or the key, at the position) on insert
// or its right neighbor on delete, and flags a position hit and a key match for the reduction tree.
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0,
    parameter int CNT_W      = 9
) (
    input  wire logic                  aclk,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [DATA_WIDTH-1:0] key,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic [CNT_W-1:0]      count,
    output logic      [DATA_WIDTH-1:0] data,
    output logic                       hit_pos,
    output logic                       hit_key
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  at_pos;
    logic                  above_pos;
    logic                  in_list;

    assign at_pos    = (int'(ctrl.pos) == INDEX);
    assign above_pos = (INDEX > int'(ctrl.pos));
    assign in_list   = (INDEX < int'(count));

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (above_pos) begin
                data_next = left_data;
            end else if (at_pos) begin
                data_next = key;
            end
        end else if (ctrl.del) begin
            // everything from the removed slot upward moves down one
            if (above_pos || at_pos) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign hit_pos = at_pos;
    assign hit_key = in_list && (data_reg == key);

endmodule
`default_nettype wire

// ===== rtl/sle_group.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sle_group - first-level reduction over a group of cells
// Registers the word at the requested position and the lowest matching
// offset of the group.
// ----------------------------------------------------------------------------
module sle_group import sle_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   capture,
    input  wire logic [GROUP_SIZE-1:0]  sel,
    input  wire logic [GROUP_SIZE-1:0]  match,
    input  wire logic [DATA_WIDTH-1:0]  word [GROUP_SIZE],
    output logic                        sel_any,
    output logic      [DATA_WIDTH-1:0]  sel_word,
    output logic                        match_any,
    output logic      [GROUP_OFF_W-1:0] match_off
);

    logic                   sel_any_reg,   sel_any_next;
    logic [DATA_WIDTH-1:0]  sel_word_reg,  sel_word_next;
    logic                   match_any_reg, match_any_next;
    logic [GROUP_OFF_W-1:0] match_off_reg, match_off_next;

    always_comb begin
        sel_any_next   = |sel;
        match_any_next = |match;
        sel_word_next  = '0;
        match_off_next = '0;
        for (int i = 0; i < GROUP_SIZE; i++) begin
            sel_word_next = sel_word_next | (word[i] & {DATA_WIDTH{sel[i]}});
        end
        // scan downward so the lowest match wins
        for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
            if (match[i]) begin
                match_off_next = GROUP_OFF_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            sel_any_reg   <= sel_any_next;
            sel_word_reg  <= sel_word_next;
            match_any_reg <= match_any_next;
            match_off_reg <= match_off_next;
        end
    end

    assign sel_any   = sel_any_reg;
    assign sel_word  = sel_word_reg;
    assign match_any = match_any_reg;
    assign match_off = match_off_reg;

endmodule
`default_nettype wire

// ===== bench/sequential_list_engine_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine_tb - self-checking bench for the sequential list engine
// Drives insert, delete, read, find, clear and spare request codes. A shadow
// copy of the list predicts each result, and a monitor checks every result
// beat against the oldest prediction. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module sequential_list_engine_tb import sle_pkg::*; ;

    localparam int CAPACITY    = 256;
    localparam int CYCLE_LIMIT = 400000;

    // request codes the block does not implement
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [7:0]  found_index;
        logic [8:0]  list_length;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = OP_CLEAR;
    logic [7:0]  s_position = 8'd0;
    logic [31:0] s_item_value = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_read_value;
    logic [7:0]  m_found_index;
    logic [8:0]  m_list_length;

    // shadow copy of the list
    logic [31:0]  shadow_list [CAPACITY];
    int           shadow_len = 0;
    list_result_t expected_results [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;

    sequential_list_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (32)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_position    (s_position),
        .s_item_value  (s_item_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_found_index (m_found_index),
        .m_list_length (m_list_length)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sequential_list_engine");
            $finish;
        end
    end

    // Apply one request to the shadow list and return the result it gives.
    function automatic list_result_t apply_request(logic [2:0] op, logic [7:0] pos,
                                                   logic [31:0] val);
        list_result_t r;
        int i;
        r = '0;
        r.status = STAT_OK;
        case (op)
            OP_INSERT: begin
                if (pos > shadow_len) begin
                    r.status = STAT_BADPOS;
                end else if (shadow_len >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos] = val;
                    shadow_len++;
                end
            end
            OP_DELETE: begin
                if (shadow_len == 0) begin
                    r.status = STAT_EMPTY;
                end else if (pos >= shadow_len) begin
                    r.status = STAT_BADPOS;
                end else begin
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                end
            end
            OP_READ: begin
                if (pos >= shadow_len)
                    r.status = STAT_BADPOS;
                else
                    r.read_value = shadow_list[pos];
            end
            OP_FIND: begin
                // scan downward so the lowest match is the one kept
                r.status = STAT_NOTFOUND;
                for (i = shadow_len - 1; i >= 0; i--) begin
                    if (shadow_list[i] == val) begin
                        r.status = STAT_OK;
                        r.found_index = 8'(i);
                    end
                end
            end
            OP_CLEAR: shadow_len = 0;
            default: r.status = STAT_BADPOS;
        endcase
        r.list_length = 9'(shadow_len);
        return r;
    endfunction

    // Called at a falling edge; returns at a falling edge after the beat.
    task automatic send_request(input logic [2:0] op, input logic [7:0] pos,
                                input logic [31:0] val);
        int gap;
        s_valid      <= 1'b1;
        s_op         <= op;
        s_position   <= pos;
        s_item_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(apply_request(op, pos, val));
        @(negedge aclk);
        if (send_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Result side stalls in random bursts.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        list_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no request outstanding");
                mismatch_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_status);
                    mismatch_count++;
                end
                if (m_read_value !== exp_r.read_value) begin
                    $error("read_value: expected %h, got %h",
                           exp_r.read_value, m_read_value);
                    mismatch_count++;
                end
                if (m_found_index !== exp_r.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           exp_r.found_index, m_found_index);
                    mismatch_count++;
                end
                if (m_list_length !== exp_r.list_length) begin
                    $error("list_length: expected %0d, got %0d",
                           exp_r.list_length, m_list_length);
                    mismatch_count++;
                end
            end
        end
    end

    // Edge positions, every code, and each refusal but the full list.
    task automatic test_directed();
        send_request(OP_READ,   8'd0,   32'h0000_0000);
        send_request(OP_DELETE, 8'd0,   32'h0000_0000);
        send_request(OP_FIND,   8'd0,   32'h0000_0000);
        send_request(OP_INSERT, 8'd1,   32'h1234_5678);
        send_request(OP_INSERT, 8'd0,   32'h8000_0000);
        send_request(OP_INSERT, 8'd1,   32'h7FFF_FFFF);
        send_request(OP_INSERT, 8'd1,   32'h0000_0000);
        send_request(OP_INSERT, 8'd0,   32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd4,   32'h7FFF_FFFF);
        send_request(OP_READ,   8'd0,   32'h0000_0000);
        send_request(OP_READ,   8'd4,   32'h0000_0000);
        send_request(OP_READ,   8'd5,   32'h0000_0000);
        send_request(OP_FIND,   8'd0,   32'h7FFF_FFFF);
        send_request(OP_FIND,   8'd255, 32'h0001_2345);
        send_request(OP_DELETE, 8'd5,   32'h0000_0000);
        send_request(OP_DELETE, 8'd255, 32'h0000_0000);
        send_request(OP_DELETE, 8'd1,   32'h0000_0000);
        send_request(OP_DELETE, 8'd3,   32'h0000_0000);
        send_request(OP_DELETE, 8'd0,   32'h0000_0000);
        send_request(OP_READ,   8'd255, 32'hFFFF_FFFF);
        send_request(OP_SPARE_5, 8'd255, 32'hFFFF_FFFF);
        send_request(OP_SPARE_6, 8'd0,   32'h0000_0000);
        send_request(OP_SPARE_7, 8'd128, 32'h5555_AAAA);
        send_request(OP_CLEAR,  8'd255, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd255, 32'h0000_0001);
    endtask

    // Fill to the last slot, push against the full list, then back off.
    task automatic test_fill_to_capacity();
        int pos;
        send_request(OP_CLEAR, 8'd0, 32'h0);
        while (shadow_len < CAPACITY) begin
            pos = $urandom_range(0, shadow_len > 255 ? 255 : shadow_len);
            send_request(OP_INSERT, 8'(pos), $urandom());
        end
        send_request(OP_INSERT, 8'd0,   $urandom());
        send_request(OP_INSERT, 8'd255, $urandom());
        send_request(OP_READ,   8'd255, 32'h0);
        send_request(OP_FIND,   8'd0,   shadow_list[255]);
        send_request(OP_FIND,   8'd0,   shadow_list[0]);
        send_request(OP_DELETE, 8'd255, 32'h0);
        send_request(OP_INSERT, 8'd255, 32'h8000_0000);
        send_request(OP_READ,   8'd255, 32'h0);
        send_request(OP_DELETE, 8'd0,   32'h0);
        send_request(OP_DELETE, 8'd128, 32'h0);
    endtask

    // Mostly legal positions; stored values reused, mostly for finds; some noise.
    task automatic test_random_ops(input int n_items);
        int roll;
        int k;
        logic [2:0]  op;
        logic [7:0]  pos;
        logic [31:0] val;
        for (k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 38)      op = OP_INSERT;
            else if (roll < 63) op = OP_DELETE;
            else if (roll < 78) op = OP_READ;
            else if (roll < 95) op = OP_FIND;
            else if (roll < 97) op = OP_CLEAR;
            else                op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));

            if ($urandom_range(0, 9) == 0 || shadow_len == 0 || shadow_len > 255)
                pos = 8'($urandom_range(0, 255));
            else if (op == OP_INSERT)
                pos = 8'($urandom_range(0, shadow_len));
            else
                pos = 8'($urandom_range(0, shadow_len - 1));

            // reuse stored values to make duplicates and finds that hit
            if (shadow_len > 0 && $urandom_range(0, 9) < (op == OP_FIND ? 7 : 2))
                val = shadow_list[$urandom_range(0, shadow_len - 1)];
            else if ($urandom_range(0, 4) == 0)
                val = 32'($signed($urandom_range(0, 7)) - 4);
            else
                val = $urandom();
            send_request(op, pos, val);
        end
    endtask

    task automatic test_random_bursty();
        int blk;
        for (blk = 0; blk < 8; blk++) begin
            // leave some stretches free of idling
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            test_random_ops(40);
        end
    endtask

    task automatic test_back_to_back();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        test_random_ops(60);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_fill_to_capacity();
        test_random_bursty();
        test_back_to_back();

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS sequential_list_engine");
        else
            $display("FAIL sequential_list_engine");
        $finish;
    end

endmodule
`default_nettype wire
